>>> hw/rtl/yuv420_color_balance_unit_macros.svh
// Assertion macros for the color balance RTL.
// Included by the top module, the only one that carries concurrent checks; depends on nothing.
`ifndef YUV420_COLOR_BALANCE_UNIT_MACROS_SVH
`define YUV420_COLOR_BALANCE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/cbu_pkg.sv
// Shared types, constants and saturation helpers for the color balance unit.
// Used by every module of the block except cbu_ram; depends on nothing.
package cbu_pkg;

   localparam int NUM_LUMA   = 4;
   localparam int TBL_DEPTH  = 256;
   localparam int ADDR_W     = 8;
   localparam int LUMA_W     = 8;
   localparam int OFFSET_W   = 9;
   localparam int GAIN_W     = 10;
   localparam int VALUE_W    = 11;
   localparam int CHROMA_W   = 8;

   localparam int OFFSET_MIN = -128;
   localparam int OFFSET_MAX = 128;
   localparam int GAIN_MAX   = 512;
   localparam int LUMA_MAX   = 255;
   localparam int CHROMA_BIAS = 128;
   localparam int LIMITED_LO = 16;
   localparam int LIMITED_HI = 239;
   localparam int FULL_HI    = 255;
   localparam int GAIN_SHIFT = 8;
   localparam int AVG_SHIFT  = 2;

   // Request beat layout.
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int IDX_LSB    = 0;
   localparam int VAL_LSB    = 8;
   localparam int LUMA_LSB   = 19;
   localparam int CB_LSB     = 51;
   localparam int CR_LSB     = 59;
   localparam int RSP_DATA_W = 48;

   typedef enum logic {
      CMD_WRITE   = 1'b0,
      CMD_PROCESS = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      TBL_LUMA   = 2'd0,
      TBL_CB_OFF = 2'd1,
      TBL_CR_OFF = 2'd2,
      TBL_GAIN   = 2'd3
   } tbl_sel_type;

   typedef struct packed {
      logic                       en;
      tbl_sel_type                sel;
      logic [ADDR_W-1:0]          index;
      logic [LUMA_W-1:0]          luma_val;
      logic signed [OFFSET_W-1:0] offset_val;
      logic [GAIN_W-1:0]          gain_val;
   } tbl_wr_type;

   typedef struct packed {
      logic load_b;
      logic load_c;
   } pipe_ctl_type;

   function automatic logic [LUMA_W-1:0] sat_luma(input logic signed [VALUE_W-1:0] v);
      logic [LUMA_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > VALUE_W'(LUMA_MAX)) begin
         r = LUMA_W'(LUMA_MAX);
      end else begin
         r = v[LUMA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [OFFSET_W-1:0] sat_offset(
      input logic signed [VALUE_W-1:0] v);
      logic signed [VALUE_W-1:0]  lo;
      logic signed [VALUE_W-1:0]  hi;
      logic signed [OFFSET_W-1:0] r;
      lo = VALUE_W'(OFFSET_MIN);
      hi = VALUE_W'(OFFSET_MAX);
      if (v < lo) begin
         r = OFFSET_W'(OFFSET_MIN);
      end else if (v > hi) begin
         r = OFFSET_W'(OFFSET_MAX);
      end else begin
         r = v[OFFSET_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] sat_gain(input logic signed [VALUE_W-1:0] v);
      logic [GAIN_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > VALUE_W'(GAIN_MAX)) begin
         r = GAIN_W'(GAIN_MAX);
      end else begin
         r = v[GAIN_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [CHROMA_W-1:0] clamp_chroma(input logic signed [10:0] v,
                                                       input logic limited);
      logic signed [10:0]  lo;
      logic signed [10:0]  hi;
      logic [CHROMA_W-1:0] r;
      lo = limited ? 11'(LIMITED_LO) : 11'sd0;
      hi = limited ? 11'(LIMITED_HI) : 11'(FULL_HI);
      if (v < lo) begin
         r = lo[CHROMA_W-1:0];
      end else if (v > hi) begin
         r = hi[CHROMA_W-1:0];
      end else begin
         r = v[CHROMA_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/yuv420_color_balance_unit.sv
// Color balance for 4:2:0 video: luma curve plus luma-dependent chroma shift
// and saturation. Depends on cbu_pkg, cbu_table_lane, cbu_chroma_path and the
// assertion macro header.
//
// Usage: the request stream carries two kinds of beats, chosen by req_tuser[0].
// A write beat stores one saturated entry into the table given by
// req_tuser[2:1]; it is absorbed in the cycle it is accepted and gives no
// response. A process beat carries a 2x2 luma group with its Cb and Cr
// samples and yields exactly one response beat with the four curved lumas
// and the corrected chroma. Responses leave in request order.
// A process beat passes through three register stages (table read, multiply,
// sum and clamp) and is presented on the response channel from the last one.
// Throughput: one beat per cycle unless a low rsp_tready stalls the stages, limited
// by the single read port of each table copy; every luma of the group has its own
// copy of the four tables. A write beat followed directly by a process beat sees the new entry.
// When the receiver holds rsp_tready low, the three stages fill up and
// req_tready drops only once all of them hold a result.
// Reset clears the stage valid bits and limited_range; table contents are
// unknown until written by the host. csr_we writes limited_range and must
// only be used while no process beat is in flight.
`include "yuv420_color_balance_unit_macros.svh"

module yuv420_color_balance_unit
   import cbu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // table_index, table_value, luma_a, luma_b, luma_c, luma_d, cb_in, cr_in, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command, table_select
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // luma_out_a, luma_out_b, luma_out_c, luma_out_d, cb_out, cr_out
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic                       limited_range_ff;
   logic                       accept;
   logic                       proc;
   tbl_wr_type                 wr;
   logic signed [VALUE_W-1:0]  value_w;

   logic                       adv_a;
   logic                       adv_b;
   logic                       adv_c;
   pipe_ctl_type               ctl;

   logic                       valid_a_ff;
   logic                       valid_a_in;
   logic                       valid_b_ff;
   logic                       valid_b_in;
   logic                       valid_c_ff;
   logic                       valid_c_in;

   logic signed [7:0]          cb_a_ff;
   logic signed [7:0]          cr_a_ff;
   logic [LUMA_W-1:0]          curve_a [NUM_LUMA];
   logic signed [OFFSET_W-1:0] cb_off_a [NUM_LUMA];
   logic signed [OFFSET_W-1:0] cr_off_a [NUM_LUMA];
   logic [GAIN_W-1:0]          gain_a [NUM_LUMA];
   logic [LUMA_W-1:0]          luma_b_ff [NUM_LUMA];
   logic [LUMA_W-1:0]          luma_c_ff [NUM_LUMA];
   logic [CHROMA_W-1:0]        cb_out;
   logic [CHROMA_W-1:0]        cr_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         limited_range_ff <= 1'b0;
      end else if (csr_we) begin
         limited_range_ff <= csr_wdata;
      end
   end

   // Backpressure runs from the response register back to the request side.
   assign adv_c      = !valid_c_ff || rsp_tready;
   assign adv_b      = !valid_b_ff || adv_c;
   assign adv_a      = !valid_a_ff || adv_b;
   assign req_tready = adv_a;
   assign ctl.load_b = valid_a_ff && adv_b;
   assign ctl.load_c = valid_b_ff && adv_c;

   assign accept = req_tvalid && req_tready;
   assign proc   = accept && (req_tuser[0] == CMD_PROCESS);

   always_comb begin
      value_w       = $signed(req_tdata[VAL_LSB +: VALUE_W]);
      wr.en         = accept && (req_tuser[0] == CMD_WRITE);
      wr.sel        = tbl_sel_type'(req_tuser[2:1]);
      wr.index      = req_tdata[IDX_LSB +: ADDR_W];
      wr.luma_val   = sat_luma(value_w);
      wr.offset_val = sat_offset(value_w);
      wr.gain_val   = sat_gain(value_w);
   end

   for (genvar i = 0; i < NUM_LUMA; i++) begin : g_lane
      cbu_table_lane u_lane (
         .clock     (clock),
         .wr        (wr),
         .rd_en     (proc),
         .rd_addr   (req_tdata[LUMA_LSB + i*LUMA_W +: LUMA_W]),
         .curve     (curve_a[i]),
         .cb_offset (cb_off_a[i]),
         .cr_offset (cr_off_a[i]),
         .gain      (gain_a[i])
      );
   end

   assign valid_a_in = adv_a ? proc : valid_a_ff;
   assign valid_b_in = adv_b ? valid_a_ff : valid_b_ff;
   assign valid_c_in = adv_c ? valid_b_ff : valid_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
      end
   end

   // Flipping the top bit turns offset binary into the centered value c - 128.
   always_ff @(posedge clock) begin
      if (proc) begin
         cb_a_ff <= $signed({~req_tdata[CB_LSB + 7], req_tdata[CB_LSB +: 7]});
         cr_a_ff <= $signed({~req_tdata[CR_LSB + 7], req_tdata[CR_LSB +: 7]});
      end
      if (ctl.load_b) begin
         luma_b_ff <= curve_a;
      end
      if (ctl.load_c) begin
         luma_c_ff <= luma_b_ff;
      end
   end

   cbu_chroma_path u_cb_path (
      .clock         (clock),
      .ctl           (ctl),
      .limited_range (limited_range_ff),
      .centered      (cb_a_ff),
      .offset        (cb_off_a),
      .gain          (gain_a),
      .chroma_out    (cb_out)
   );

   cbu_chroma_path u_cr_path (
      .clock         (clock),
      .ctl           (ctl),
      .limited_range (limited_range_ff),
      .centered      (cr_a_ff),
      .offset        (cr_off_a),
      .gain          (gain_a),
      .chroma_out    (cr_out)
   );

   assign rsp_tvalid = valid_c_ff;
   assign rsp_tdata  = {cr_out, cb_out, luma_c_ff[3], luma_c_ff[2],
                        luma_c_ff[1], luma_c_ff[0]};

   `CBU_ASSERT_NEXT(a_proc_enters_stage_a, clock, reset, proc, valid_a_ff)
   `CBU_ASSERT_NEXT(a_stage_a_moves_on, clock, reset, ctl.load_b, valid_b_ff)
   `CBU_ASSERT_SAME(a_empty_output_ready, clock, reset, !valid_c_ff, req_tready)

endmodule

>>> hw/rtl/cbu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for every lookup table copy in the color balance unit.
module cbu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/cbu_table_lane.sv
// One copy of the four luma-indexed tables, serving a single luma of the group.
// Depends on cbu_pkg and cbu_ram.
module cbu_table_lane
   import cbu_pkg::*;
(
   input  logic                       clock,
   input  tbl_wr_type                 wr,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [LUMA_W-1:0]          curve,
   output logic signed [OFFSET_W-1:0] cb_offset,
   output logic signed [OFFSET_W-1:0] cr_offset,
   output logic [GAIN_W-1:0]          gain
);

   logic                wr_luma;
   logic                wr_cb;
   logic                wr_cr;
   logic                wr_gain;
   logic [OFFSET_W-1:0] cb_raw;
   logic [OFFSET_W-1:0] cr_raw;

   always_comb begin
      wr_luma = 1'b0;
      wr_cb   = 1'b0;
      wr_cr   = 1'b0;
      wr_gain = 1'b0;
      case (wr.sel)
         TBL_LUMA:   wr_luma = wr.en;
         TBL_CB_OFF: wr_cb   = wr.en;
         TBL_CR_OFF: wr_cr   = wr.en;
         TBL_GAIN:   wr_gain = wr.en;
         default:    wr_luma = 1'b0;
      endcase
   end

   cbu_ram #(.WIDTH(LUMA_W), .DEPTH(TBL_DEPTH)) u_curve_ram (
      .clock   (clock),
      .wr_en   (wr_luma),
      .wr_addr (wr.index),
      .wr_data (wr.luma_val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (curve)
   );

   cbu_ram #(.WIDTH(OFFSET_W), .DEPTH(TBL_DEPTH)) u_cb_ram (
      .clock   (clock),
      .wr_en   (wr_cb),
      .wr_addr (wr.index),
      .wr_data (wr.offset_val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cb_raw)
   );

   cbu_ram #(.WIDTH(OFFSET_W), .DEPTH(TBL_DEPTH)) u_cr_ram (
      .clock   (clock),
      .wr_en   (wr_cr),
      .wr_addr (wr.index),
      .wr_data (wr.offset_val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cr_raw)
   );

   cbu_ram #(.WIDTH(GAIN_W), .DEPTH(TBL_DEPTH)) u_gain_ram (
      .clock   (clock),
      .wr_en   (wr_gain),
      .wr_addr (wr.index),
      .wr_data (wr.gain_val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (gain)
   );

   assign cb_offset = $signed(cb_raw);
   assign cr_offset = $signed(cr_raw);

endmodule

>>> hw/rtl/cbu_chroma_path.sv
// Chroma correction for one channel: offset, gain and shift per luma, then
// average, re-bias and clamp. Two register stages. Depends on cbu_pkg.
module cbu_chroma_path
   import cbu_pkg::*;
(
   input  logic                       clock,
   input  pipe_ctl_type               ctl,
   input  logic                       limited_range,
   input  logic signed [7:0]          centered,
   input  logic signed [OFFSET_W-1:0] offset [NUM_LUMA],
   input  logic [GAIN_W-1:0]          gain [NUM_LUMA],
   output logic [CHROMA_W-1:0]        chroma_out
);

   logic signed [9:0]          term_in [NUM_LUMA];
   logic signed [9:0]          term_ff [NUM_LUMA];
   logic signed [11:0]         sum_w;
   logic signed [10:0]         biased_w;
   logic [CHROMA_W-1:0]        chroma_in;
   logic [CHROMA_W-1:0]        chroma_ff;

   // Each term is floor(((c - 128) + offset) * gain / 256).
   always_comb begin
      logic signed [9:0]  adj;
      logic signed [20:0] prod;
      for (int i = 0; i < NUM_LUMA; i++) begin
         adj        = {{2{centered[7]}}, centered} + {offset[i][OFFSET_W-1], offset[i]};
         prod       = adj * $signed({1'b0, gain[i]});
         term_in[i] = 10'(prod >>> GAIN_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_b) begin
         term_ff <= term_in;
      end
   end

   always_comb begin
      sum_w = '0;
      for (int i = 0; i < NUM_LUMA; i++) begin
         sum_w = sum_w + {{2{term_ff[i][9]}}, term_ff[i]};
      end
      // Floor average of the four terms, then back to offset binary.
      biased_w  = 11'(sum_w >>> AVG_SHIFT) + 11'(CHROMA_BIAS);
      chroma_in = clamp_chroma(biased_w, limited_range);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_c) begin
         chroma_ff <= chroma_in;
      end
   end

   assign chroma_out = chroma_ff;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 4:2:0 color balance unit (luma curve plus
// luma-indexed chroma offset and gain). Needs cbu_pkg and the unit's RTL.
// A scoreboard class predicts every response and checks it field by field.
module testbench;
   import cbu_pkg::*;

   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      cmd_type            cmd;
      tbl_sel_type        sel;
      logic [7:0]         index;
      logic signed [10:0] value;
      logic [3:0][7:0]    luma;
      logic [7:0]         cb;
      logic [7:0]         cr;
   } pixel_request_type;

   class balance_checker;
      logic [7:0]        curve_tbl [256];
      logic signed [8:0] cb_off_tbl [256];
      logic signed [8:0] cr_off_tbl [256];
      logic [9:0]        gain_tbl [256];
      bit                limited;
      logic [5:0][7:0]   expected_groups [$];
      string             field_names [6];
      int                errors;
      int                checked;

      function new();
         limited = 1'b0;
         errors = 0;
         checked = 0;
         field_names = '{"luma_out_a", "luma_out_b", "luma_out_c", "luma_out_d",
                         "cb_out", "cr_out"};
      endfunction

      function int pending();
         return expected_groups.size();
      endfunction

      function int clip(int v, int lo, int hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Each luma contributes its own floored (c - 128 + offset) * gain / 256 term;
      // the four terms are summed and floored again by four.
      function logic [7:0] predict_chroma(logic [7:0] c, bit is_cr,
                                          logic [3:0][7:0] lumas);
         int cv;
         int offs;
         int g;
         int acc;
         int lo;
         int hi;
         cv = c;
         acc = 0;
         for (int i = 0; i < 4; i++) begin
            offs = is_cr ? cr_off_tbl[lumas[i]] : cb_off_tbl[lumas[i]];
            g = gain_tbl[lumas[i]];
            acc += ((cv - CHROMA_BIAS + offs) * g) >>> GAIN_SHIFT;
         end
         lo = limited ? LIMITED_LO : 0;
         hi = limited ? LIMITED_HI : FULL_HI;
         return 8'(clip((acc >>> AVG_SHIFT) + CHROMA_BIAS, lo, hi));
      endfunction

      function void note_request(pixel_request_type it);
         int v;
         logic [5:0][7:0] exp_group;
         v = it.value;
         if (it.cmd == CMD_WRITE) begin
            case (it.sel)
               TBL_LUMA:   curve_tbl[it.index] = 8'(clip(v, 0, LUMA_MAX));
               TBL_CB_OFF: cb_off_tbl[it.index] = 9'(clip(v, OFFSET_MIN, OFFSET_MAX));
               TBL_CR_OFF: cr_off_tbl[it.index] = 9'(clip(v, OFFSET_MIN, OFFSET_MAX));
               default:    gain_tbl[it.index] = 10'(clip(v, 0, GAIN_MAX));
            endcase
         end else begin
            for (int i = 0; i < 4; i++) begin
               exp_group[i] = curve_tbl[it.luma[i]];
            end
            exp_group[4] = predict_chroma(it.cb, 1'b0, it.luma);
            exp_group[5] = predict_chroma(it.cr, 1'b1, it.luma);
            expected_groups.push_back(exp_group);
         end
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         logic [5:0][7:0] got;
         logic [5:0][7:0] want;
         got = data;
         if (expected_groups.size() == 0) begin
            report($sformatf("response beat with nothing expected: %h", data));
         end else begin
            want = expected_groups.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got[i] !== want[i]) begin
                  report($sformatf("response %0d %s: got %0d, expected %0d",
                                   checked, field_names[i], got[i], want[i]));
               end
            end
         end
         checked++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic                  csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   balance_checker sb = new();

   // Generator view of the tables: an entry may only be read once written.
   bit [3:0]          entry_written [256];
   bit                entry_usable [256];
   logic [7:0]        usable_levels [$];
   pixel_request_type gen_queue [$];
   bit                hold_request = 1'b0;
   int                idle_cycles = 0;

   yuv420_color_balance_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic pixel_request_type random_filler();
      pixel_request_type it;
      it.cmd = cmd_type'($urandom_range(0, 1));
      it.sel = tbl_sel_type'($urandom_range(0, 3));
      it.index = 8'($urandom);
      it.value = 11'($urandom);
      for (int i = 0; i < 4; i++) begin
         it.luma[i] = 8'($urandom);
      end
      it.cb = 8'($urandom);
      it.cr = 8'($urandom);
      return it;
   endfunction

   function automatic void mark_written(tbl_sel_type s, logic [7:0] idx);
      entry_written[idx][s] = 1'b1;
      if (entry_written[idx] == 4'hf && !entry_usable[idx]) begin
         entry_usable[idx] = 1'b1;
         usable_levels.push_back(idx);
      end
   endfunction

   function automatic logic signed [10:0] pick_value(tbl_sel_type s);
      int r;
      int lo;
      int hi;
      r = $urandom_range(0, 9);
      lo = (s == TBL_CB_OFF || s == TBL_CR_OFF) ? OFFSET_MIN : 0;
      hi = (s == TBL_LUMA) ? LUMA_MAX : ((s == TBL_GAIN) ? GAIN_MAX : OFFSET_MAX);
      if (r < 5) begin
         return 11'(lo + int'($urandom_range(0, hi - lo)));
      end else if (r < 8) begin
         return 11'($urandom);
      end else begin
         case ($urandom_range(0, 5))
            0:       return 11'(lo - 1);
            1:       return 11'(lo);
            2:       return 11'(hi);
            3:       return 11'(hi + 1);
            4:       return -11'sd1024;
            default: return 11'sd1023;
         endcase
      end
   endfunction

   function automatic logic [7:0] pick_chroma();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd128;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void refill_stimulus();
      pixel_request_type it;
      int                r;
      int                start;
      logic [7:0]        idx;
      r = $urandom_range(0, 99);
      if (r < 18) begin
         // Load all four tables at one luma level, starting at a random table.
         idx = 8'($urandom);
         start = $urandom_range(0, 3);
         for (int k = 0; k < 4; k++) begin
            it = random_filler();
            it.cmd = CMD_WRITE;
            it.sel = tbl_sel_type'((start + k) % 4);
            it.index = idx;
            it.value = pick_value(it.sel);
            gen_queue.push_back(it);
            mark_written(it.sel, idx);
         end
      end else if (r < 30) begin
         it = random_filler();
         it.cmd = CMD_WRITE;
         if ($urandom_range(0, 1) == 1) begin
            it.index = usable_levels[$urandom_range(0, usable_levels.size() - 1)];
         end
         it.value = pick_value(it.sel);
         gen_queue.push_back(it);
         mark_written(it.sel, it.index);
      end else begin
         it = random_filler();
         it.cmd = CMD_PROCESS;
         for (int i = 0; i < 4; i++) begin
            it.luma[i] = usable_levels[$urandom_range(0, usable_levels.size() - 1)];
         end
         if ($urandom_range(0, 4) == 0) begin
            it.luma = {4{it.luma[0]}};
         end
         it.cb = pick_chroma();
         it.cr = pick_chroma();
         gen_queue.push_back(it);
      end
   endfunction

   task automatic send(input pixel_request_type it);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[IDX_LSB +: ADDR_W] = it.index;
      d[VAL_LSB +: VALUE_W] = it.value;
      for (int i = 0; i < 4; i++) begin
         d[LUMA_LSB + 8 * i +: 8] = it.luma[i];
      end
      d[CB_LSB +: CHROMA_W] = it.cb;
      d[CR_LSB +: CHROMA_W] = it.cr;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = d;
      req_tuser = {it.sel, it.cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
   endtask

   task automatic hold_idle(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   task automatic write_entry(input tbl_sel_type s, input logic [7:0] idx, input int v);
      pixel_request_type it;
      it = random_filler();
      it.cmd = CMD_WRITE;
      it.sel = s;
      it.index = idx;
      it.value = 11'(v);
      mark_written(s, idx);
      send(it);
   endtask

   task automatic process_group(input logic [3:0][7:0] lumas, input logic [7:0] cb,
                                input logic [7:0] cr);
      pixel_request_type it;
      it = random_filler();
      it.cmd = CMD_PROCESS;
      it.luma = lumas;
      it.cb = cb;
      it.cr = cr;
      send(it);
   endtask

   task automatic directed_groups();
      process_group({4{8'd0}}, 8'd0, 8'd255);
      process_group({4{8'd255}}, 8'd255, 8'd0);
      process_group({4{8'd128}}, 8'd0, 8'd255);
      process_group({8'd1, 8'd128, 8'd255, 8'd0}, 8'd128, 8'd128);
      process_group({8'd0, 8'd255, 8'd128, 8'd1}, 8'd0, 8'd0);
      process_group({4{8'd1}}, 8'd255, 8'd255);
   endtask

   task automatic set_range(input bit v);
      hold_idle(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.limited = v;
   endtask

   task automatic run_random(input int count, input int max_gap);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            if (gen_queue.size() == 0) refill_stimulus();
            send(gen_queue.pop_front());
            sent++;
         end
         if (max_gap > 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                              : $urandom_range(0, max_gap);
            if (gap > 0) hold_idle(gap);
         end
      end
      hold_idle(1);
   endtask

   // Receiver: the ready pattern changes among four modes at random; on request
   // it holds off for a long stretch so that the pipeline fills.
   initial begin
      int mode;
      int left;
      rsp_tready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(8, 64);
         end
         left--;
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = ($urandom_range(0, 3) != 0);
            2:       rsp_tready = ($urandom_range(0, 1) != 0);
            default: rsp_tready = (left % 5 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no beat moved for %0d cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extreme and out-of-range entries at four luma levels; level 128 is unity.
      write_entry(TBL_LUMA, 8'd0, -1024);
      write_entry(TBL_CB_OFF, 8'd0, -1024);
      write_entry(TBL_CR_OFF, 8'd0, 1023);
      write_entry(TBL_GAIN, 8'd0, 1023);
      write_entry(TBL_LUMA, 8'd255, 1023);
      write_entry(TBL_CB_OFF, 8'd255, 129);
      write_entry(TBL_CR_OFF, 8'd255, -129);
      write_entry(TBL_GAIN, 8'd255, -1);
      write_entry(TBL_LUMA, 8'd128, 128);
      write_entry(TBL_CB_OFF, 8'd128, 0);
      write_entry(TBL_CR_OFF, 8'd128, 0);
      write_entry(TBL_GAIN, 8'd128, 256);
      write_entry(TBL_LUMA, 8'd1, 255);
      write_entry(TBL_CB_OFF, 8'd1, -128);
      write_entry(TBL_CR_OFF, 8'd1, 128);
      write_entry(TBL_GAIN, 8'd1, 512);
      directed_groups();
      // A process beat right behind a write must see the new entry.
      write_entry(TBL_GAIN, 8'd128, 513);
      process_group({4{8'd128}}, 8'd200, 8'd50);

      set_range(1'b1);
      directed_groups();

      set_range(1'b0);
      run_random(120, 6);

      set_range(1'b1);
      @(negedge clock);
      hold_request = 1'b1;
      run_random(40, 0);
      run_random(100, 4);

      set_range(1'b0);
      run_random(120, 0);

      set_range(1'b1);
      run_random(130, 8);

      set_range(1'($urandom_range(0, 1)));
      run_random(120, 3);

      hold_idle(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
